### hdl/mfd_pkg.sv
// Shared types, constants and helpers of the modulated feedback delay.
package mfd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int DLEN_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] HASH_MUL_A = 32'd2246822507;
    localparam logic [31:0] HASH_MUL_B = 32'd3266489909;
    localparam logic [9:0]  PHASE_MUL  = 10'd997;

    localparam logic [14:0] FB_MAX    = 15'd31130;
    localparam logic [15:0] MIX_MAX   = 16'd32768;
    localparam logic [16:0] LVL_MAX   = 17'd65536;
    localparam logic [16:0] LVL_RESET = 17'd32768;
    localparam logic [14:0] DEPTH_MAX = 15'd16384;
    localparam logic [15:0] VAR_MAX   = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEEDBACK_GAIN  = 3'd0,
        REG_WET_MIX        = 3'd1,
        REG_OUTPUT_LEVEL   = 3'd2,
        REG_MOD_DEPTH      = 3'd3,
        REG_MOD_RATE_STEP  = 3'd4,
        REG_MOD_VARIATION  = 3'd5,
        REG_INVERT_MODE    = 3'd6,
        REG_VARIATION_SEED = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] dry_sample;
        logic [DLEN_W-1:0]          delay_length;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_out;
        logic signed [SAMPLE_W-1:0] wet_out;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_HIDX, ST_H1, ST_H2, ST_DIFF, ST_LVL, ST_VAR,
        ST_FAC, ST_INC, ST_LFO, ST_M1, ST_M2, ST_RP, ST_RD0, ST_RD1,
        ST_I0, ST_I1, ST_FB, ST_WR, ST_KEEP, ST_FW, ST_MX0, ST_MX1,
        ST_L0, ST_OUT
    } step_t;

    typedef struct packed {
        step_t step;
        logic  load;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } status_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (x < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

### hdl/mfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mfd_ctrl.sv
// Sequencing state machine and handshake control of the delay block.
module mfd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  mfd_pkg::status_t status,
    output mfd_pkg::cmd_t    cmd
);

    mfd_pkg::step_t state_reg, state_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mfd_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        out_load   = (state_reg == mfd_pkg::ST_OUT) && (!out_valid_reg || m_ready);
        state_next = state_reg;
        unique case (state_reg)
            mfd_pkg::ST_CLEAR: if (status.clear_done) state_next = mfd_pkg::ST_IDLE;
            mfd_pkg::ST_IDLE:  if (s_valid) state_next = mfd_pkg::ST_HIDX;
            mfd_pkg::ST_HIDX:  state_next = mfd_pkg::ST_H1;
            mfd_pkg::ST_H1:    state_next = mfd_pkg::ST_H2;
            mfd_pkg::ST_H2:    state_next = mfd_pkg::ST_DIFF;
            mfd_pkg::ST_DIFF:  state_next = mfd_pkg::ST_LVL;
            mfd_pkg::ST_LVL:   state_next = mfd_pkg::ST_VAR;
            mfd_pkg::ST_VAR:   state_next = mfd_pkg::ST_FAC;
            mfd_pkg::ST_FAC:   state_next = mfd_pkg::ST_INC;
            mfd_pkg::ST_INC:   state_next = mfd_pkg::ST_LFO;
            mfd_pkg::ST_LFO:   state_next = mfd_pkg::ST_M1;
            mfd_pkg::ST_M1:    state_next = mfd_pkg::ST_M2;
            mfd_pkg::ST_M2:    state_next = mfd_pkg::ST_RP;
            mfd_pkg::ST_RP:    state_next = mfd_pkg::ST_RD0;
            mfd_pkg::ST_RD0:   state_next = mfd_pkg::ST_RD1;
            mfd_pkg::ST_RD1:   state_next = mfd_pkg::ST_I0;
            mfd_pkg::ST_I0:    state_next = mfd_pkg::ST_I1;
            mfd_pkg::ST_I1:    state_next = mfd_pkg::ST_FB;
            mfd_pkg::ST_FB:    state_next = mfd_pkg::ST_WR;
            mfd_pkg::ST_WR:    state_next = mfd_pkg::ST_KEEP;
            mfd_pkg::ST_KEEP:  state_next = mfd_pkg::ST_FW;
            mfd_pkg::ST_FW:    state_next = mfd_pkg::ST_MX0;
            mfd_pkg::ST_MX0:   state_next = mfd_pkg::ST_MX1;
            mfd_pkg::ST_MX1:   state_next = mfd_pkg::ST_L0;
            mfd_pkg::ST_L0:    state_next = mfd_pkg::ST_OUT;
            mfd_pkg::ST_OUT:   if (out_load) state_next = mfd_pkg::ST_IDLE;
            default:           state_next = mfd_pkg::ST_CLEAR;
        endcase

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign s_ready      = (state_reg == mfd_pkg::ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign cmd.step     = state_reg;
    assign cmd.load     = s_valid && s_ready;
    assign cmd.out_load = out_load;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == mfd_pkg::ST_HIDX))
        else $error("accepted word did not start processing");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfd_pkg::ST_CLEAR) |-> !s_ready)
        else $error("input ready during clearing pass");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfd_pkg::ST_OUT && m_valid && !m_ready) |=>
        (state_reg == mfd_pkg::ST_OUT && m_valid))
        else $error("result overwritten while stalled");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before taken");

endmodule

### hdl/mfd_dpath.sv
// Datapath of the delay block: registers, arithmetic and delay store.
module mfd_dpath #(
    parameter int BUFFER_DEPTH = 262144
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfd_pkg::cmd_t                       cmd,
    output mfd_pkg::status_t                    status,
    input  mfd_pkg::in_word_t                   s_word,
    output mfd_pkg::out_word_t                  m_word,
    input  logic                                cfg_wr_en,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW  = mfd_pkg::SAMPLE_W;
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int DW  = (AW + 8 > mfd_pkg::DLEN_W) ? AW + 8 : mfd_pkg::DLEN_W;
    localparam logic [DW-1:0] DMAX = DW'((BUFFER_DEPTH - 2) * 256);
    localparam logic [DW-1:0] DMIN = DW'(256);

    // configuration
    logic [14:0] fb_reg, depth_reg;
    logic [15:0] mix_reg, var_reg;
    logic [16:0] lvl_reg;
    logic [31:0] step_reg, seed_reg;
    logic        inv_reg;

    // state
    logic [AW-1:0] wi_reg, clr_cnt_reg;
    logic [31:0]   phase_reg;
    logic signed [31:0] level_reg;

    // working registers
    logic signed [SW-1:0] dry_reg;
    logic [mfd_pkg::DLEN_W-1:0] dlen_reg;
    logic [31:0] hidx_reg, hv_reg, fac_reg;
    logic [30:0] keep_reg;
    logic signed [32:0] diff_reg;
    logic signed [48:0] p_reg;
    logic [16:0] lfo_reg;
    logic [DW-1:0] d_reg;
    logic [DW+16:0] m1_reg;
    logic [DW:0] off_reg;
    logic [AW-1:0] before_reg, after_reg;
    logic [7:0] frac_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic signed [SW+9:0] acc_reg;
    logic signed [SW:0] wet_reg, fbw_reg, t1_reg, t2_reg;
    logic signed [SW+1:0] fwet_reg;
    logic signed [SW+19:0] acc2_reg;
    logic signed [SW+4:0] mixa_reg;
    logic signed [SW-1:0] mix_sat_reg;
    mfd_pkg::out_word_t out_reg;

    // combinational helpers
    logic [63:0] phase_prod, inc_prod;
    logic [31:0] v1, v2, v3;
    logic [63:0] h1_prod, h2_prod;
    logic [29:0] fb_sq;
    logic [32:0] mag;
    logic [64:0] mag_prod;
    logic signed [33:0] delta, level_sum;
    logic signed [48:0] p_abs;
    logic signed [33:0] q;
    logic signed [33:0] factor;
    logic [32:0] neg_phase;
    logic [DW+16:0] m1_prod;
    logic [DW+31:0] m2_prod;
    logic [DW:0] x_val;
    logic [AW-1:0] wi_new;
    logic [AW+7:0] rp;
    logic signed [SW+9:0] i0_prod, i1_sum;
    logic signed [SW+40:0] fb_prod;
    logic signed [SW+16:0] t1_prod;
    logic signed [SW+32:0] t2_prod;
    logic signed [SW+1:0] wr;
    logic signed [SW+19:0] mx1_sum;
    logic signed [SW+22:0] l0_prod;
    logic signed [SW+19:0] wo_prod;
    logic [SW-1:0] ram_rdata;
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [SW-1:0] ram_wdata;

    always_comb begin
        phase_prod = 64'(phase_reg) * 64'(mfd_pkg::PHASE_MUL);
        v1         = hidx_reg ^ seed_reg;
        v1         = v1 ^ (v1 >> 16);
        h1_prod    = 64'(v1) * 64'(mfd_pkg::HASH_MUL_A);
        v2         = hv_reg ^ (hv_reg >> 13);
        h2_prod    = 64'(v2) * 64'(mfd_pkg::HASH_MUL_B);
        v3         = hv_reg ^ (hv_reg >> 16);
        fb_sq      = 30'(fb_reg) * 30'(fb_reg);
        mag        = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        mag_prod   = 65'(mag) * 65'(step_reg);
        delta      = $signed({1'b0, mag_prod[64:32]});
        level_sum  = diff_reg[32] ? (34'(level_reg) - delta) : (34'(level_reg) + delta);
        p_abs      = p_reg[48] ? -p_reg : p_reg;
        q          = p_reg[48] ? -$signed(34'(p_abs >>> 15)) : $signed(34'(p_abs >>> 15));
        factor     = 34'sh0_8000_0000 + q;
        inc_prod   = 64'(step_reg) * 64'(fac_reg);
        neg_phase  = 33'h1_0000_0000 - 33'(phase_reg);
        m1_prod    = (DW+17)'(d_reg) * (DW+17)'(lfo_reg);
        m2_prod    = (DW+32)'(m1_reg) * (DW+32)'(depth_reg);
        x_val      = (DW+1)'(m2_prod >> 31);
        wi_new     = wi_reg + AW'(1);
        rp         = {wi_new, 8'd0} - off_reg[AW+7:0];
        i0_prod    = s0_reg * $signed({1'b0, 9'(9'd256 - 9'(frac_reg))});
        i1_sum     = acc_reg + s1_reg * $signed({2'b00, frac_reg});
        fb_prod    = wet_reg * $signed({1'b0, fb_reg});
        t1_prod    = dry_reg * $signed({1'b0, fb_reg});
        t2_prod    = wet_reg * $signed({1'b0, keep_reg});
        wr         = inv_reg ? (-(SW+2)'(dry_reg) - (SW+2)'(fbw_reg))
                             : ((SW+2)'(dry_reg) + (SW+2)'(fbw_reg));
        mx1_sum    = acc2_reg + fwet_reg * $signed({1'b0, mix_reg});
        l0_prod    = mixa_reg * $signed({1'b0, lvl_reg});
        wo_prod    = fwet_reg * $signed({1'b0, lvl_reg});

        ram_we    = (cmd.step == mfd_pkg::ST_CLEAR) || (cmd.step == mfd_pkg::ST_WR);
        ram_waddr = (cmd.step == mfd_pkg::ST_CLEAR) ? clr_cnt_reg : wi_reg;
        ram_wdata = (cmd.step == mfd_pkg::ST_CLEAR) ? '0
                                                    : mfd_pkg::sat_sample(64'(wr));
        ram_raddr = (cmd.step == mfd_pkg::ST_RD0) ? before_reg : after_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg      <= '0;
            mix_reg     <= '0;
            lvl_reg     <= mfd_pkg::LVL_RESET;
            depth_reg   <= '0;
            step_reg    <= '0;
            var_reg     <= '0;
            inv_reg     <= 1'b0;
            seed_reg    <= '0;
            wi_reg      <= '0;
            clr_cnt_reg <= '0;
            phase_reg   <= '0;
            level_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (mfd_pkg::cfg_idx_t'(cfg_index))
                    mfd_pkg::REG_FEEDBACK_GAIN:
                        fb_reg <= (cfg_data[14:0] > mfd_pkg::FB_MAX) ? mfd_pkg::FB_MAX
                                                                     : cfg_data[14:0];
                    mfd_pkg::REG_WET_MIX:
                        mix_reg <= (cfg_data[15:0] > mfd_pkg::MIX_MAX) ? mfd_pkg::MIX_MAX
                                                                       : cfg_data[15:0];
                    mfd_pkg::REG_OUTPUT_LEVEL:
                        lvl_reg <= (cfg_data[16:0] > mfd_pkg::LVL_MAX) ? mfd_pkg::LVL_MAX
                                                                       : cfg_data[16:0];
                    mfd_pkg::REG_MOD_DEPTH:
                        depth_reg <= (cfg_data[14:0] > mfd_pkg::DEPTH_MAX)
                                     ? mfd_pkg::DEPTH_MAX : cfg_data[14:0];
                    mfd_pkg::REG_MOD_RATE_STEP:  step_reg <= cfg_data;
                    mfd_pkg::REG_MOD_VARIATION:
                        var_reg <= (cfg_data[15:0] > mfd_pkg::VAR_MAX) ? mfd_pkg::VAR_MAX
                                                                       : cfg_data[15:0];
                    mfd_pkg::REG_INVERT_MODE:    inv_reg <= cfg_data[0];
                    mfd_pkg::REG_VARIATION_SEED: seed_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.step == mfd_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.step == mfd_pkg::ST_LVL) begin
                level_reg <= level_sum[31:0];
            end
            if (cmd.step == mfd_pkg::ST_INC) begin
                phase_reg <= phase_reg + inc_prod[62:31];
            end
            if (cmd.step == mfd_pkg::ST_RP) begin
                wi_reg <= wi_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dry_reg  <= s_word.dry_sample;
            dlen_reg <= s_word.delay_length;
        end
        unique case (cmd.step)
            mfd_pkg::ST_HIDX: hidx_reg <= phase_prod[63:32] + 32'(wi_reg);
            mfd_pkg::ST_H1:   hv_reg <= h1_prod[31:0];
            mfd_pkg::ST_H2:   hv_reg <= h2_prod[31:0];
            mfd_pkg::ST_DIFF: begin
                diff_reg <= $signed({~v3[31], ~v3[31], v3[30:0]}) - 33'(level_reg);
                keep_reg <= 31'h4000_0000 - 31'(fb_sq);
            end
            mfd_pkg::ST_VAR:  p_reg <= level_reg * $signed({1'b0, var_reg});
            mfd_pkg::ST_FAC:  fac_reg <= factor[31:0];
            mfd_pkg::ST_LFO: begin
                lfo_reg <= phase_reg[31] ? neg_phase[31:15] : {1'b0, phase_reg[30:15]};
                if (DW'(dlen_reg) < DMIN) begin
                    d_reg <= DMIN;
                end else if (DW'(dlen_reg) > DMAX) begin
                    d_reg <= DMAX;
                end else begin
                    d_reg <= DW'(dlen_reg);
                end
            end
            mfd_pkg::ST_M1:   m1_reg <= m1_prod;
            mfd_pkg::ST_M2:   off_reg <= (DW+1)'(d_reg) - x_val + (DW+1)'(256);
            mfd_pkg::ST_RP: begin
                before_reg <= rp[AW+7:8];
                after_reg  <= rp[AW+7:8] + AW'(1);
                frac_reg   <= rp[7:0];
            end
            mfd_pkg::ST_RD1:  s0_reg <= ram_rdata;
            mfd_pkg::ST_I0: begin
                acc_reg <= i0_prod;
                s1_reg  <= ram_rdata;
            end
            mfd_pkg::ST_I1:   wet_reg <= (SW+1)'(i1_sum >>> 8);
            mfd_pkg::ST_FB:   fbw_reg <= (SW+1)'(fb_prod >>> 15);
            mfd_pkg::ST_WR:   t1_reg <= (SW+1)'(t1_prod >>> 15);
            mfd_pkg::ST_KEEP: t2_reg <= (SW+1)'(t2_prod >>> 30);
            mfd_pkg::ST_FW:   fwet_reg <= inv_reg ? ((SW+2)'(t1_reg) - (SW+2)'(t2_reg))
                                                  : (SW+2)'(wet_reg);
            mfd_pkg::ST_MX0:  acc2_reg <= dry_reg * $signed({1'b0, 17'(17'd32768 - 17'(mix_reg))});
            mfd_pkg::ST_MX1:  mixa_reg <= (SW+5)'(mx1_sum >>> 15);
            mfd_pkg::ST_L0:   mix_sat_reg <= mfd_pkg::sat_sample(64'(l0_prod >>> 15));
            mfd_pkg::ST_OUT: begin
                if (cmd.out_load) begin
                    out_reg.mixed_out <= mix_sat_reg;
                    out_reg.wet_out   <= mfd_pkg::sat_sample(64'(wo_prod >>> 15));
                end
            end
            default: ;
        endcase
    end

    assign status.clear_done = (cmd.step == mfd_pkg::ST_CLEAR) && (&clr_cnt_reg);
    assign m_word = out_reg;

    mfd_ram #(
        .WIDTH (SW),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### hdl/modulated_feedback_delay_top.sv
// Top level of the modulated feedback delay line.
// Input channel s_valid/s_ready/s_word carries one word: a Q3.20 dry sample
// and a delay length in samples with 8 fractional bits.
// Result channel m_valid/m_ready/m_word returns one word per input word:
// the mixed output and the wet output, both saturated.
// Registers are written through cfg_wr_en/cfg_index/cfg_data, one per
// cycle; the user must write them only while no word is in flight.
// Each word walks a 24-step sequence through one shared datapath; a new
// word is taken only once its result is loaded into the output register
// and the sequencer is back in idle. The delay store is a single RAM read
// twice and written once per word.
// After reset a clearing pass zeroes the store, one entry per cycle, and
// s_ready stays low until it ends. Registers may be written during the
// pass.
// A finished result waits in the output register while the next word is
// accepted and processed; if m_ready is still low when that word is done,
// the sequencer holds until the waiting result is taken.
module modulated_feedback_delay_top #(
    parameter int BUFFER_DEPTH = 262144
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mfd_pkg::in_word_t              s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mfd_pkg::out_word_t             m_word,
    input  logic                           cfg_wr_en,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0] cfg_data
);

    mfd_pkg::cmd_t    cmd;
    mfd_pkg::status_t status;

    mfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mfd_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_word    (s_word),
        .m_word    (m_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
